@@ src/rgb_to_hsv_color_convert_top_defines.svh @@
// Assertion macros shared by the checker of the RGB to HSV converter.
// No dependencies; included by the checker file.
`ifndef RGB_TO_HSV_COLOR_CONVERT_TOP_DEFINES_SVH
`define RGB_TO_HSV_COLOR_CONVERT_TOP_DEFINES_SVH

// Implication checked outside reset.
`define RHC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhc assertion failed");

// Next-cycle implication that is also checked while reset is high.
`define RHC_ASSERT_RST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rhc reset assertion failed");

`endif

@@ src/rhc_pkg.sv @@
// Shared types and constants of the RGB to HSV converter.
// No dependencies; used by every module of the block.
`default_nettype none

package rhc_pkg;

   // field widths
   localparam int PIXEL_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int HUE_W     = 9;
   localparam int SAT_W     = 16;

   // default number of saturation fraction bits
   localparam int SAT_FRAC_BITS_DEF = 16;

   // hue division: quotient is at most 60, so 6 bits; numerator fits 14 bits
   localparam int HUE_Q_BITS   = 6;
   localparam int HUE_NUM_BITS = 14;

   localparam int HUE_SECTOR_DEG = 60;

   typedef logic [CHAN_W-1:0]       chan_type;
   typedef logic [HUE_NUM_BITS-1:0] hue_num_type;
   typedef logic [HUE_Q_BITS-1:0]   hue_q_type;
   typedef logic [HUE_W:0]          hue_wide_type;
   typedef logic [HUE_W-1:0]        hue_type;
   typedef logic [SAT_W-1:0]        sat_type;
   typedef logic [1:0]              sector_type;

   localparam hue_wide_type HUE_WRAP_DEG  = hue_wide_type'(360);
   localparam hue_wide_type HUE_BASE_RED  = hue_wide_type'(0);
   localparam hue_wide_type HUE_BASE_GRN  = hue_wide_type'(120);
   localparam hue_wide_type HUE_BASE_BLU  = hue_wide_type'(240);

   // which channel holds the maximum
   localparam sector_type SECT_RED   = 2'd0;
   localparam sector_type SECT_GREEN = 2'd1;
   localparam sector_type SECT_BLUE  = 2'd2;

   // per-item data that travels down the divider chain
   typedef struct packed {
      logic        grey;      // delta is zero: hue and saturation are zero
      logic        neg;       // hue offset is subtracted from the sector base
      sector_type  sector;
      hue_num_type hue_rem;   // partial remainder of the hue division
      chan_type    hue_div;   // delta
      hue_q_type   hue_q;     // hue offset quotient, built MSB first
      chan_type    value;     // max channel, also the saturation divisor
   } rhc_side_type;

endpackage

`default_nettype wire

@@ src/rhc_prep.sv @@
// Front stage: max/min/delta, hue sector and both division numerators.
// Depends on rhc_pkg.
`default_nettype none

module rhc_prep #(
   parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [rhc_pkg::PIXEL_W-1:0] pixel_rgb,
   output logic                            out_valid,
   output rhc_pkg::rhc_side_type           out_side,
   output logic [SAT_FRAC_BITS+7:0]        out_sat_rem
);

   localparam int SW = SAT_FRAC_BITS + rhc_pkg::CHAN_W;

   rhc_pkg::chan_type     r, g, b, mx, mn, delta, hi, lo, x;
   rhc_pkg::rhc_side_type side_in, side_ff;
   logic [SW-1:0]         sat_rem_in, sat_rem_ff;
   logic                  valid_ff;

   assign r = pixel_rgb[23:16];
   assign g = pixel_rgb[15:8];
   assign b = pixel_rgb[7:0];

   // channel extremes, sector and numerators
   always_comb begin
      side_in = '0;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;

      // ties go to red, then green
      if (mx == r) begin
         side_in.sector = rhc_pkg::SECT_RED;
         hi = g;
         lo = b;
      end else if (mx == g) begin
         side_in.sector = rhc_pkg::SECT_GREEN;
         hi = b;
         lo = r;
      end else begin
         side_in.sector = rhc_pkg::SECT_BLUE;
         hi = r;
         lo = g;
      end

      side_in.neg = (lo > hi);
      x = side_in.neg ? (lo - hi) : (hi - lo);

      // negative offsets round toward minus infinity: ceil of the magnitude
      side_in.hue_rem = rhc_pkg::hue_num_type'(x)
                      * rhc_pkg::hue_num_type'(rhc_pkg::HUE_SECTOR_DEG)
                      + (side_in.neg ? rhc_pkg::hue_num_type'(delta)
                                       - rhc_pkg::hue_num_type'(1)
                                     : '0);
      side_in.hue_div = delta;
      side_in.hue_q   = '0;
      side_in.value   = mx;
      side_in.grey    = (delta == '0);

      // (2^F - 1) * delta
      sat_rem_in = (SW'(delta) << SAT_FRAC_BITS) - SW'(delta);
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff    <= side_in;
      sat_rem_ff <= sat_rem_in;
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_sat_rem = sat_rem_ff;

endmodule

`default_nettype wire

@@ src/rhc_div_cell.sv @@
// One cell of the divider chain: resolves one saturation quotient bit and,
// in the first six cells, one hue quotient bit. Depends on rhc_pkg.
`default_nettype none

module rhc_div_cell #(
   parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF,
   parameter int STAGE         = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire rhc_pkg::rhc_side_type       in_side,
   input  wire logic [SAT_FRAC_BITS+7:0]    in_sat_rem,
   input  wire logic [SAT_FRAC_BITS-1:0]    in_sat_q,
   output logic                             out_valid,
   output rhc_pkg::rhc_side_type            out_side,
   output logic [SAT_FRAC_BITS+7:0]         out_sat_rem,
   output logic [SAT_FRAC_BITS-1:0]         out_sat_q
);

   localparam int SW        = SAT_FRAC_BITS + rhc_pkg::CHAN_W;
   localparam int SAT_SHIFT = SAT_FRAC_BITS - 1 - STAGE;
   localparam int HUE_SHIFT = rhc_pkg::HUE_Q_BITS - 1 - STAGE;

   rhc_pkg::rhc_side_type side_in, side_ff;
   logic [SW-1:0]            sat_den, sat_rem_in, sat_rem_ff;
   logic [SAT_FRAC_BITS-1:0] sat_q_in, sat_q_ff;
   logic                     sat_ge, valid_ff;

   // saturation step: trial subtract of max shifted to this bit
   always_comb begin
      sat_den    = SW'(in_side.value) << SAT_SHIFT;
      sat_ge     = (in_sat_rem >= sat_den);
      sat_rem_in = sat_ge ? (in_sat_rem - sat_den) : in_sat_rem;
      sat_q_in   = in_sat_q | (SAT_FRAC_BITS'(sat_ge) << SAT_SHIFT);
   end

   // hue step, only in the cells that own a hue quotient bit
   generate
      if (STAGE < rhc_pkg::HUE_Q_BITS) begin : g_hue
         rhc_pkg::hue_num_type hue_den;

         always_comb begin
            side_in = in_side;
            hue_den = rhc_pkg::hue_num_type'(in_side.hue_div) << HUE_SHIFT;
            if (in_side.hue_rem >= hue_den) begin
               side_in.hue_rem          = in_side.hue_rem - hue_den;
               side_in.hue_q[HUE_SHIFT] = 1'b1;
            end
         end
      end else begin : g_pass
         always_comb begin
            side_in = in_side;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff    <= side_in;
      sat_rem_ff <= sat_rem_in;
      sat_q_ff   <= sat_q_in;
   end

   assign out_valid   = valid_ff;
   assign out_side    = side_ff;
   assign out_sat_rem = sat_rem_ff;
   assign out_sat_q   = sat_q_ff;

endmodule

`default_nettype wire

@@ src/rhc_finish.sv @@
// Output stage: adds the hue offset to the sector base, or subtracts it when neg
// is set, wraps into 0..359, zeroes grey pixels and registers the result. Depends on rhc_pkg.
`default_nettype none

module rhc_finish #(
   parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire rhc_pkg::rhc_side_type     in_side,
   input  wire logic [SAT_FRAC_BITS-1:0]  in_sat_q,
   output logic                           out_strobe,
   output rhc_pkg::hue_type               out_hue,
   output rhc_pkg::sat_type               out_sat,
   output rhc_pkg::chan_type              out_value
);

   rhc_pkg::hue_wide_type base, hue_sum;
   rhc_pkg::hue_type      hue_in, hue_ff;
   rhc_pkg::sat_type      sat_in, sat_ff;
   rhc_pkg::chan_type     value_ff;
   logic                  strobe_ff;

   // sector base
   always_comb begin
      unique case (in_side.sector)
         rhc_pkg::SECT_RED:   base = rhc_pkg::HUE_BASE_RED;
         rhc_pkg::SECT_GREEN: base = rhc_pkg::HUE_BASE_GRN;
         rhc_pkg::SECT_BLUE:  base = rhc_pkg::HUE_BASE_BLU;
         default:             base = rhc_pkg::HUE_BASE_RED;
      endcase
   end

   // offset and wrap; a negative offset is taken from base + 360
   always_comb begin
      if (in_side.neg) begin
         hue_sum = base + rhc_pkg::HUE_WRAP_DEG
                 - rhc_pkg::hue_wide_type'(in_side.hue_q);
      end else begin
         hue_sum = base + rhc_pkg::hue_wide_type'(in_side.hue_q);
      end
      if (hue_sum >= rhc_pkg::HUE_WRAP_DEG) begin
         hue_sum = hue_sum - rhc_pkg::HUE_WRAP_DEG;
      end
      hue_in = in_side.grey ? '0 : rhc_pkg::hue_type'(hue_sum);
      // wider fractions are masked to the field, narrower ones zero-extended
      sat_in = in_side.grey ? '0 : rhc_pkg::sat_type'(in_sat_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      value_ff <= in_side.value;
   end

   assign out_strobe = strobe_ff;
   assign out_hue    = hue_ff;
   assign out_sat    = sat_ff;
   assign out_value  = value_ff;

endmodule

`default_nettype wire

@@ src/rgb_to_hsv_color_convert_top.sv @@
// Top level of the RGB to HSV converter: front stage, divider cell chain,
// output stage. Depends on rhc_pkg, rhc_prep, rhc_div_cell, rhc_finish.
//
// Usage:
//   Drive req_pixel_rgb (red 23..16, green 15..8, blue 7..0) and raise
//   start; the item is taken at a clock edge where start is high and busy
//   is low. busy is always low: one item can be taken every cycle.
//   Each result appears on rsp_hue, rsp_saturation and rsp_value for one
//   cycle with rsp_strobe high, in order. Throughput is one item per cycle.
//   The divider chain holds one registered cell per saturation quotient
//   bit, each resolving one bit per cycle (the hue quotient is finished in
//   the first six cells), between the front stage and the output register.
//   The receiver cannot stall; results must be captured when strobed.
//   Synchronous reset drops every item in flight and clears rsp_strobe;
//   the data registers are not reset.
`default_nettype none

module rgb_to_hsv_color_convert_top #(
   parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rhc_pkg::PIXEL_W-1:0]   req_pixel_rgb,
   output logic                               rsp_strobe,
   output logic [rhc_pkg::HUE_W-1:0]          rsp_hue,
   output logic [rhc_pkg::SAT_W-1:0]          rsp_saturation,
   output logic [rhc_pkg::CHAN_W-1:0]         rsp_value
);

   localparam int SW = SAT_FRAC_BITS + rhc_pkg::CHAN_W;

   logic                     chain_valid [0:SAT_FRAC_BITS];
   rhc_pkg::rhc_side_type    chain_side  [0:SAT_FRAC_BITS];
   logic [SW-1:0]            chain_rem   [0:SAT_FRAC_BITS];
   logic [SAT_FRAC_BITS-1:0] chain_q     [0:SAT_FRAC_BITS];

   // fully pipelined: never refuses an item
   assign busy = 1'b0;

   rhc_prep #(
      .SAT_FRAC_BITS (SAT_FRAC_BITS)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start & ~busy),
      .pixel_rgb   (req_pixel_rgb),
      .out_valid   (chain_valid[0]),
      .out_side    (chain_side[0]),
      .out_sat_rem (chain_rem[0])
   );

   assign chain_q[0] = '0;

   // divider chain, one quotient bit per cell
   generate
      for (genvar i = 0; i < SAT_FRAC_BITS; i++) begin : g_cell
         rhc_div_cell #(
            .SAT_FRAC_BITS (SAT_FRAC_BITS),
            .STAGE         (i)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .in_valid    (chain_valid[i]),
            .in_side     (chain_side[i]),
            .in_sat_rem  (chain_rem[i]),
            .in_sat_q    (chain_q[i]),
            .out_valid   (chain_valid[i+1]),
            .out_side    (chain_side[i+1]),
            .out_sat_rem (chain_rem[i+1]),
            .out_sat_q   (chain_q[i+1])
         );
      end
   endgenerate

   rhc_finish #(
      .SAT_FRAC_BITS (SAT_FRAC_BITS)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[SAT_FRAC_BITS]),
      .in_side    (chain_side[SAT_FRAC_BITS]),
      .in_sat_q   (chain_q[SAT_FRAC_BITS]),
      .out_strobe (rsp_strobe),
      .out_hue    (rsp_hue),
      .out_sat    (rsp_saturation),
      .out_value  (rsp_value)
   );

endmodule

`default_nettype wire

@@ src/rhc_checker.sv @@
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsv_color_convert_top_defines.svh.
`default_nettype none

`include "rgb_to_hsv_color_convert_top_defines.svh"

module rhc_checker #(
   parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_strobe,
   input wire logic [rhc_pkg::HUE_W-1:0]    rsp_hue,
   input wire logic [rhc_pkg::SAT_W-1:0]    rsp_saturation,
   input wire logic [rhc_pkg::CHAN_W-1:0]   rsp_value
);

   localparam int LAT = SAT_FRAC_BITS + 2;

   logic accept;
   logic value_zero;
   logic sat_zero;

   assign accept     = start & ~busy;
   assign value_zero = (rsp_value == '0);
   assign sat_zero   = (rsp_saturation == '0);

   // every result stems from an accepted item, sampled with $past at depth LAT
   `RHC_ASSERT_IMPL(a_strobe_latency, clock, reset, rsp_strobe, $past(accept, LAT))

   // no result right after reset
   `RHC_ASSERT_RST(a_reset_clears, clock, reset, !rsp_strobe)

   // hue stays wrapped
   `RHC_ASSERT_IMPL(a_hue_range, clock, reset, rsp_strobe, rsp_hue < rhc_pkg::HUE_W'(360))

   // black pixel gives zero hue and saturation
   `RHC_ASSERT_IMPL(a_black_zero, clock, reset, rsp_strobe && value_zero, (rsp_hue == '0) && sat_zero)

   // zero saturation with nonzero value means grey, hence zero hue
   `RHC_ASSERT_IMPL(a_grey_hue, clock, reset, rsp_strobe && sat_zero && !value_zero, rsp_hue == '0)

endmodule

bind rgb_to_hsv_color_convert_top rhc_checker #(
   .SAT_FRAC_BITS (SAT_FRAC_BITS)
) u_rhc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_value      (rsp_value)
);

`default_nettype wire
